// File: rtl/adaptive_cliff_threshold_macros.svh
// assertion macros for the adaptive cliff threshold block
`ifndef ADAPTIVE_CLIFF_THRESHOLD_MACROS_SVH
`define ADAPTIVE_CLIFF_THRESHOLD_MACROS_SVH

// same-cycle implication, checked outside reset
`define ACT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ACT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/act_pkg.sv
// shared types and constants for the adaptive cliff threshold block
`default_nettype none

package act_pkg;

  localparam int SAMPLE_W = 16;
  localparam int DIGIT_W  = 16;
  localparam int LIMIT_W  = 31;
  localparam int TALLY_W  = 8;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_DRIVE = 2'd0,
    OP_STOP  = 2'd1,
    OP_SCAN  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DROP_LEVEL    = 3'd0,
    CFG_MIN_THRESHOLD = 3'd1,
    CFG_THRESH_STEP   = 3'd2,
    CFG_SUSP_NEEDED   = 3'd3,
    CFG_VAR_LIMIT     = 3'd4,
    CFG_MIN_RISE      = 3'd5,
    CFG_ADJUST_EN     = 3'd6
  } cfg_idx_t;

  localparam logic [SAMPLE_W-1:0] DROP_LEVEL_RST    = 16'd800;
  localparam logic [SAMPLE_W-1:0] MIN_THRESHOLD_RST = 16'd150;
  localparam logic [SAMPLE_W-1:0] THRESH_STEP_RST   = 16'd250;
  localparam logic [TALLY_W-1:0]  SUSP_NEEDED_RST   = 8'd1;
  localparam logic [LIMIT_W-1:0]  VAR_LIMIT_RST     = 31'd10000;
  localparam logic [SAMPLE_W-1:0] MIN_RISE_RST      = 16'd15;
  localparam logic [SAMPLE_W-1:0] SCAN_MIN_RST      = 16'hFFFF;

endpackage

`default_nettype wire

// File: rtl/adaptive_cliff_threshold.sv
// adaptive cliff threshold with sliding-window variance test, top level
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_ready  operation sample wheels_moving on_treads scan_last
//  out      output     out_valid/out_ready  threshold threshold_sent floor_cliffy
//                                           suspicious_seen window_fill
//  cfg      input      cfg_we               cfg_index cfg_data
//
// one item at a time; each product goes through one shared digit-serial multiplier
// a product is built one 16-bit digit of the sum-wide operand at a time, 2 digits by default
// variance test uses four products once 2 samples are held; a push adds one, two when full
// in_ready is low from a transfer until the result is loaded into the output register
// a stalled output holds the sequencer in its last step; synchronous reset, no clearing pass
`default_nettype none
`include "adaptive_cliff_threshold_macros.svh"

module adaptive_cliff_threshold
  import act_pkg::*;
#(
  parameter int WINDOW = 100
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           operation,
  input  logic [SAMPLE_W-1:0]  sample,
  input  logic                 wheels_moving,
  input  logic                 on_treads,
  input  logic                 scan_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SAMPLE_W-1:0]  threshold,
  output logic                 threshold_sent,
  output logic                 floor_cliffy,
  output logic                 suspicious_seen,
  output logic [6:0]           window_fill,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data
);

  localparam int CW   = $clog2(WINDOW + 1);
  localparam int IW   = $clog2(WINDOW);
  localparam int SUMW = SAMPLE_W + CW;
  localparam int SQW  = 2 * SAMPLE_W + CW;
  localparam int VW   = 2 * SUMW;
  localparam int PW   = SQW + SUMW;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_OLD, S_NEW, S_VAR, S_LHS, S_SQ, S_LN, S_RHS, S_CMP, S_SCAN, S_DONE
  } state_t;

  // configuration registers
  logic [SAMPLE_W-1:0] drop_level, min_threshold, threshold_step, min_rise;
  logic [TALLY_W-1:0]  suspicious_needed;
  logic [LIMIT_W-1:0]  variance_limit;
  logic                adjust_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_level        <= DROP_LEVEL_RST;
      min_threshold     <= MIN_THRESHOLD_RST;
      threshold_step    <= THRESH_STEP_RST;
      suspicious_needed <= SUSP_NEEDED_RST;
      variance_limit    <= VAR_LIMIT_RST;
      min_rise          <= MIN_RISE_RST;
      adjust_enable     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DROP_LEVEL:    drop_level        <= cfg_data[SAMPLE_W-1:0];
        CFG_MIN_THRESHOLD: min_threshold     <= cfg_data[SAMPLE_W-1:0];
        CFG_THRESH_STEP:   threshold_step    <= cfg_data[SAMPLE_W-1:0];
        CFG_SUSP_NEEDED:   suspicious_needed <= cfg_data[TALLY_W-1:0];
        CFG_VAR_LIMIT:     variance_limit    <= cfg_data;
        CFG_MIN_RISE:      min_rise          <= cfg_data[SAMPLE_W-1:0];
        CFG_ADJUST_EN:     adjust_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  state_t              state;
  op_t                 op;
  logic [SAMPLE_W-1:0] smp;
  logic                moving, treads, last;

  logic [CW-1:0]       fill_count;
  logic [IW-1:0]       write_slot;
  logic [SUMW-1:0]     window_sum;
  logic [SQW-1:0]      window_sumsq;
  logic [SAMPLE_W-1:0] detect_level;
  logic [TALLY_W-1:0]  suspicious_tally;
  logic [SAMPLE_W-1:0] scan_minimum;
  logic                scan_armed;

  logic                sent, seen, cliffy;
  logic [VW-1:0]       lhs, sq, rhs, diff;
  logic                lhs_gt;

  logic                mul_start, mul_done;
  logic [SQW-1:0]      mul_a;
  logic [SUMW-1:0]     mul_b;
  logic [PW-1:0]       mul_prod;

  logic [SAMPLE_W-1:0] mem [WINDOW];
  logic [SAMPLE_W-1:0] old_q;
  logic                in_xfer, mem_we, full, push;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign full     = (fill_count == CW'(WINDOW));
  assign push     = moving && treads && (smp > detect_level);
  assign mem_we   = (state == S_NEW) && mul_done;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[write_slot] <= smp;
    end
    if (in_xfer) begin
      old_q <= mem[write_slot];
    end
  end

  act_mul #(.AW(SQW), .BW(SUMW)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  // scan sample evaluation
  logic [SAMPLE_W-1:0] new_min, lowered, stepped;
  logic                rise_hit, can_count, reach;
  logic [TALLY_W-1:0]  tally_inc;

  always_comb begin
    new_min   = (smp < scan_minimum) ? smp : scan_minimum;
    rise_hit  = cliffy && ({1'b0, smp} > ({1'b0, new_min} + {1'b0, min_rise}));
    can_count = detect_level > min_threshold;
    tally_inc = suspicious_tally + 1'b1;
    reach     = tally_inc >= suspicious_needed;
    stepped   = (detect_level > threshold_step) ? (detect_level - threshold_step) : '0;
    lowered   = (stepped < min_threshold) ? min_threshold : stepped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      fill_count       <= '0;
      write_slot       <= '0;
      window_sum       <= '0;
      window_sumsq     <= '0;
      detect_level     <= DROP_LEVEL_RST;
      suspicious_tally <= '0;
      scan_minimum     <= SCAN_MIN_RST;
      scan_armed       <= 1'b0;
      mul_start        <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            op     <= op_t'(operation);
            smp    <= sample;
            moving <= wheels_moving;
            treads <= on_treads;
            last   <= scan_last;
            sent   <= 1'b0;
            seen   <= 1'b0;
            state  <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= ((op == OP_DRIVE) && push) ? (full ? S_OLD : S_NEW) : S_VAR;
          unique case (op)
            OP_DRIVE: begin
              if (push) begin
                mul_start <= 1'b1;
                if (full) begin
                  mul_a <= SQW'(old_q);
                  mul_b <= SUMW'(old_q);
                end else begin
                  mul_a <= SQW'(smp);
                  mul_b <= SUMW'(smp);
                end
              end
            end
            OP_STOP: begin
              if (adjust_enable) begin
                scan_armed   <= 1'b1;
                scan_minimum <= SCAN_MIN_RST;
              end
            end
            OP_SCAN: ;
            OP_CLEAR: begin
              suspicious_tally <= '0;
              if (detect_level != drop_level) begin
                detect_level <= drop_level;
                sent         <= 1'b1;
              end
              fill_count   <= '0;
              write_slot   <= '0;
              window_sum   <= '0;
              window_sumsq <= '0;
            end
            default: ;
          endcase
        end
        S_OLD: begin
          if (mul_done) begin
            window_sumsq <= window_sumsq - mul_prod[SQW-1:0];
            window_sum   <= window_sum - SUMW'(old_q);
            mul_a        <= SQW'(smp);
            mul_b        <= SUMW'(smp);
            mul_start    <= 1'b1;
            state        <= S_NEW;
          end else begin
            mul_start <= 1'b0;
          end
        end
        S_NEW: begin
          mul_start <= 1'b0;
          if (mul_done) begin
            window_sumsq <= window_sumsq + mul_prod[SQW-1:0];
            window_sum   <= window_sum + SUMW'(smp);
            if (!full) begin
              fill_count <= fill_count + 1'b1;
            end
            write_slot <= (write_slot == IW'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
            state      <= S_VAR;
          end
        end
        S_VAR: begin
          if (fill_count < CW'(2)) begin
            cliffy <= 1'b0;
            state  <= S_SCAN;
          end else begin
            mul_a     <= window_sumsq;
            mul_b     <= SUMW'(fill_count);
            mul_start <= 1'b1;
            state     <= S_LHS;
          end
        end
        S_LHS: begin
          if (mul_done) begin
            lhs       <= mul_prod[VW-1:0];
            mul_a     <= SQW'(window_sum);
            mul_b     <= window_sum;
            mul_start <= 1'b1;
            state     <= S_SQ;
          end else begin
            mul_start <= 1'b0;
          end
        end
        S_SQ: begin
          if (mul_done) begin
            sq        <= mul_prod[VW-1:0];
            mul_a     <= SQW'(variance_limit);
            mul_b     <= SUMW'(fill_count);
            mul_start <= 1'b1;
            state     <= S_LN;
          end else begin
            mul_start <= 1'b0;
          end
        end
        S_LN: begin
          if (mul_done) begin
            mul_a     <= mul_prod[SQW-1:0];
            mul_b     <= SUMW'(fill_count - 1'b1);
            mul_start <= 1'b1;
            state     <= S_RHS;
          end else begin
            mul_start <= 1'b0;
          end
        end
        S_RHS: begin
          mul_start <= 1'b0;
          if (mul_done) begin
            rhs    <= mul_prod[VW-1:0];
            diff   <= lhs - sq;
            lhs_gt <= lhs > sq;
            state  <= S_CMP;
          end
        end
        S_CMP: begin
          cliffy <= lhs_gt && (diff > rhs);
          state  <= S_SCAN;
        end
        S_SCAN: begin
          if ((op == OP_SCAN) && scan_armed && !moving) begin
            scan_minimum <= new_min;
            if (rise_hit) begin
              seen <= 1'b1;
              if (can_count) begin
                if (reach) begin
                  detect_level     <= lowered;
                  suspicious_tally <= '0;
                  sent             <= 1'b1;
                end else begin
                  suspicious_tally <= tally_inc;
                end
              end
            end
            if (last) begin
              scan_armed <= 1'b0;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            threshold       <= detect_level;
            threshold_sent  <= sent;
            floor_cliffy    <= cliffy;
            suspicious_seen <= seen;
            window_fill     <= 7'(fill_count);
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ACT_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !in_ready, "ready high right after a transfer")
  `ACT_ASSERT_NOW(a_slot_tracks_fill, !full, CW'(write_slot) == fill_count,
                  "write slot out of step with fill count")
  `ACT_ASSERT_NOW(a_seen_needs_cliffy, out_valid && suspicious_seen, floor_cliffy,
                  "suspicious cliff reported on a calm floor")

endmodule

`default_nettype wire

// File: rtl/act_mul.sv
// shared digit-serial multiplier, one 16-bit digit of b per cycle
`default_nettype none

module act_mul
  import act_pkg::*;
#(
  parameter int AW = 39,
  parameter int BW = 23
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] product
);

  localparam int ND   = (BW + DIGIT_W - 1) / DIGIT_W;
  localparam int BPW  = ND * DIGIT_W;
  localparam int ACCW = AW + BPW;
  localparam int CNTW = (ND > 1) ? $clog2(ND) : 1;

  logic [AW-1:0]   aq;
  logic [BPW-1:0]  bq;
  logic [ACCW-1:0] acc;
  logic [CNTW-1:0] cnt;
  logic            running;
  logic [AW+DIGIT_W-1:0] partial;

  assign partial = aq * bq[BPW-1 -: DIGIT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        aq      <= a;
        bq      <= BPW'(b);
        acc     <= '0;
        cnt     <= CNTW'(ND - 1);
      end else if (running) begin
        acc <= (acc << DIGIT_W) + ACCW'(partial);
        bq  <= bq << DIGIT_W;
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign product = acc[AW+BW-1:0];

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// testbench for adaptive_cliff_threshold: directed and random transfers checked by a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import act_pkg::*;

  localparam int WINDOW        = 100;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [SAMPLE_W-1:0] threshold;
    logic                sent;
    logic                cliffy;
    logic                seen;
    logic [6:0]          fill;
  } threshold_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           operation = '0;
  logic [SAMPLE_W-1:0]  sample = '0;
  logic                 wheels_moving = 1'b0;
  logic                 on_treads = 1'b0;
  logic                 scan_last = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SAMPLE_W-1:0]  threshold;
  logic                 threshold_sent;
  logic                 floor_cliffy;
  logic                 suspicious_seen;
  logic [6:0]           window_fill;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_data = '0;

  adaptive_cliff_threshold dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [15:0]     win_val [WINDOW];
  int unsigned     win_count, win_slot;
  longint unsigned win_sum, win_sumsq;
  int unsigned     cur_level, susp_tally, scan_low;
  bit              scan_on;
  int unsigned     r_drop, r_min_thr, r_step, r_needed, r_min_rise;
  longint unsigned r_var_limit;
  bit              r_adjust_en;

  threshold_result_t pending_results[$];
  threshold_result_t head_result;

  bit calm = 1'b0;
  int unsigned gap_odds = 4;
  int unsigned stall_odds = 4;
  int items_issued = 0;
  int results_checked = 0;
  int error_count = 0;
  int sends_seen = 0;
  int suspicious_count = 0;
  int cliffy_count = 0;
  int idle_cycles = 0;

  function automatic bit variance_exceeds();
    longint unsigned n, lhs, sq;
    n = 64'(win_count);
    if (n < 2) return 1'b0;
    lhs = n * win_sumsq;
    sq = win_sum * win_sum;
    if (lhs <= sq) return 1'b0;
    return (lhs - sq) > r_var_limit * n * (n - 1);
  endfunction

  function automatic threshold_result_t advance_threshold_model(op_t op, logic [15:0] smp,
      bit moving, bit treads, bit last);
    threshold_result_t r;
    longint unsigned old, v;
    int unsigned lowered;
    r.sent = 1'b0;
    r.seen = 1'b0;
    v = 64'(smp);
    case (op)
      OP_DRIVE: begin
        if (moving && treads && v > cur_level) begin
          if (win_count >= WINDOW) begin
            old = 64'(win_val[win_slot]);
            win_sum -= old;
            win_sumsq -= old * old;
          end else begin
            win_count++;
          end
          win_val[win_slot] = smp;
          win_sum += v;
          win_sumsq += v * v;
          win_slot = (win_slot + 1) % WINDOW;
        end
      end
      OP_STOP: begin
        if (r_adjust_en) begin
          scan_on = 1'b1;
          scan_low = 32'hFFFF;
        end
      end
      OP_SCAN: begin
        if (scan_on && !moving) begin
          if (v < scan_low) scan_low = 32'(v);
          if (variance_exceeds() && v > longint'(scan_low) + r_min_rise) begin
            r.seen = 1'b1;
            if (cur_level > r_min_thr) begin
              susp_tally = (susp_tally + 1) & 32'hFF;
              if (susp_tally >= r_needed) begin
                lowered = (cur_level > r_step) ? cur_level - r_step : 0;
                if (lowered < r_min_thr) lowered = r_min_thr;
                cur_level = lowered;
                susp_tally = 0;
                r.sent = 1'b1;
              end
            end
          end
          if (last) scan_on = 1'b0;
        end
      end
      OP_CLEAR: begin
        susp_tally = 0;
        if (cur_level != r_drop) begin
          cur_level = r_drop;
          r.sent = 1'b1;
        end
        win_count = 0;
        win_slot = 0;
        win_sum = 0;
        win_sumsq = 0;
      end
    endcase
    r.threshold = cur_level[15:0];
    r.cliffy = variance_exceeds();
    r.fill = win_count[6:0];
    return r;
  endfunction

  function automatic void check_field(string what, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
      error_count++;
    end
  endfunction

  function automatic int unsigned extreme_or_any(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic bit rand_bit();
    return bit'($urandom_range(0, 1));
  endfunction

  function automatic logic [15:0] rand_word();
    return 16'($urandom);
  endfunction

  task automatic issue_item(op_t op, logic [15:0] smp, bit moving, bit treads, bit last);
    @(negedge clk);
    if (!calm && $urandom_range(0, gap_odds) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid = 1'b1;
    operation = op;
    sample = smp;
    wheels_moving = moving;
    on_treads = treads;
    scan_last = last;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    pending_results.insert(pending_results.size(),
                           advance_threshold_model(op, smp, moving, treads, last));
    items_issued++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val[LIMIT_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_DROP_LEVEL:    r_drop = val & 32'hFFFF;
      CFG_MIN_THRESHOLD: r_min_thr = val & 32'hFFFF;
      CFG_THRESH_STEP:   r_step = val & 32'hFFFF;
      CFG_SUSP_NEEDED:   r_needed = val & 32'hFF;
      CFG_VAR_LIMIT:     r_var_limit = 64'(val & 32'h7FFF_FFFF);
      CFG_MIN_RISE:      r_min_rise = val & 32'hFFFF;
      CFG_ADJUST_EN:     r_adjust_en = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_config(int unsigned drop, int unsigned min_thr, int unsigned step,
      int unsigned needed, int unsigned limit, int unsigned rise, int unsigned adj);
    wait_idle();
    write_reg(CFG_DROP_LEVEL, drop);
    write_reg(CFG_MIN_THRESHOLD, min_thr);
    write_reg(CFG_THRESH_STEP, step);
    write_reg(CFG_SUSP_NEEDED, needed);
    write_reg(CFG_VAR_LIMIT, limit);
    write_reg(CFG_MIN_RISE, rise);
    write_reg(CFG_ADJUST_EN, adj);
  endtask

  // drive samples mostly above threshold, usually a stop, then a scan whose last item mostly sets scan_last
  task automatic run_session(int drive_len, int spread, int scan_len);
    int unsigned base, scan_lo, span, v;
    base = (cur_level < 65535) ? $urandom_range(cur_level + 1, 65535) : 65535;
    for (int i = 0; i < drive_len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        issue_item(OP_DRIVE, rand_word(), rand_bit(), rand_bit(), rand_bit());
      end else begin
        v = base + $urandom_range(0, spread);
        if (v > 65535) v = 65535;
        issue_item(OP_DRIVE, v[15:0], 1'b1, 1'b1, rand_bit());
      end
    end
    if ($urandom_range(0, 7) != 0)
      issue_item(OP_STOP, rand_word(), rand_bit(), rand_bit(), rand_bit());
    scan_lo = $urandom_range(0, 65535);
    span = 16 << $urandom_range(0, 12);
    for (int i = 0; i < scan_len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        issue_item(op_t'($urandom_range(0, 3)), rand_word(), rand_bit(), rand_bit(),
                   rand_bit());
      end else begin
        v = scan_lo + $urandom_range(0, span);
        if (v > 65535) v = 65535;
        issue_item(OP_SCAN, v[15:0], $urandom_range(0, 11) == 0, rand_bit(),
                   i == scan_len - 1);
      end
    end
  endtask

  task automatic test_directed();
    wait_idle();
    issue_item(OP_DRIVE, 1000, 1'b0, 1'b1, 1'b0);
    issue_item(OP_DRIVE, 1000, 1'b1, 1'b0, 1'b0);
    issue_item(OP_DRIVE, 800, 1'b1, 1'b1, 1'b0);
    issue_item(OP_DRIVE, 0, 1'b1, 1'b1, 1'b1);
    issue_item(OP_DRIVE, 65535, 1'b1, 1'b1, 1'b0);
    issue_item(OP_SCAN, 2000, 1'b0, 1'b1, 1'b0);
    issue_item(OP_DRIVE, 801, 1'b1, 1'b1, 1'b0);
    issue_item(OP_DRIVE, 1200, 1'b1, 1'b1, 1'b0);
    issue_item(OP_STOP, 0, 1'b0, 1'b1, 1'b0);
    issue_item(OP_SCAN, 900, 1'b1, 1'b1, 1'b1);
    issue_item(OP_SCAN, 900, 1'b0, 1'b1, 1'b0);
    issue_item(OP_SCAN, 910, 1'b0, 1'b1, 1'b0);
    issue_item(OP_SCAN, 916, 1'b0, 1'b1, 1'b0);
    issue_item(OP_SCAN, 2000, 1'b0, 1'b0, 1'b0);
    issue_item(OP_SCAN, 3000, 1'b0, 1'b1, 1'b0);
    issue_item(OP_SCAN, 4000, 1'b0, 1'b1, 1'b0);
    issue_item(OP_SCAN, 0, 1'b0, 1'b1, 1'b1);
    issue_item(OP_SCAN, 5000, 1'b0, 1'b1, 1'b0);
    issue_item(OP_CLEAR, 65535, 1'b1, 1'b1, 1'b1);
    issue_item(OP_CLEAR, 0, 1'b0, 1'b0, 1'b0);
    issue_item(OP_STOP, 65535, 1'b1, 1'b0, 1'b1);
    issue_item(OP_CLEAR, 0, 1'b0, 1'b1, 1'b0);
    issue_item(OP_SCAN, 65535, 1'b0, 1'b1, 1'b1);
    issue_item(OP_DRIVE, 65535, 1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_stop_disabled();
    wait_idle();
    write_reg(CFG_ADJUST_EN, 0);
    issue_item(OP_CLEAR, 0, 1'b0, 1'b1, 1'b0);
    issue_item(OP_DRIVE, 1000, 1'b1, 1'b1, 1'b0);
    issue_item(OP_DRIVE, 5000, 1'b1, 1'b1, 1'b0);
    issue_item(OP_DRIVE, 30000, 1'b1, 1'b1, 1'b0);
    issue_item(OP_STOP, 0, 1'b0, 1'b1, 1'b0);
    issue_item(OP_SCAN, 100, 1'b0, 1'b1, 1'b0);
    issue_item(OP_SCAN, 60000, 1'b0, 1'b1, 1'b1);
    wait_idle();
    write_reg(CFG_ADJUST_EN, 1);
    issue_item(OP_STOP, 0, 1'b0, 1'b1, 1'b0);
    issue_item(OP_SCAN, 100, 1'b0, 1'b1, 1'b0);
    issue_item(OP_SCAN, 60000, 1'b0, 1'b1, 1'b0);
    issue_item(OP_STOP, 0, 1'b0, 1'b1, 1'b0);
    issue_item(OP_SCAN, 59000, 1'b0, 1'b1, 1'b0);
    issue_item(OP_SCAN, 61000, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic test_window_wrap();
    wait_idle();
    write_reg(CFG_SUSP_NEEDED, 3);
    write_reg(CFG_VAR_LIMIT, 2000);
    issue_item(OP_CLEAR, 0, 1'b0, 1'b0, 1'b0);
    run_session(150, 3000, 8);
    run_session(120, 100, 6);
  endtask

  task automatic test_config_extremes();
    apply_config(0, 0, 65535, 1, 0, 0, 1);
    issue_item(OP_CLEAR, 0, 1'b0, 1'b0, 1'b0);
    run_session(12, $urandom_range(0, 65535), 10);
    apply_config(65535, 65535, 0, 255, 1 << 30, 65535, 1);
    issue_item(OP_CLEAR, 0, 1'b0, 1'b0, 1'b0);
    run_session(12, $urandom_range(0, 65535), 10);
    apply_config(5000, 100, 0, 2, 0, 0, 1);
    issue_item(OP_CLEAR, 0, 1'b0, 1'b0, 1'b0);
    run_session(12, 4000, 10);
    apply_config(40000, 0, 65535, 0, 1, 1, 1);
    issue_item(OP_CLEAR, 0, 1'b0, 1'b0, 1'b0);
    run_session(12, 20000, 10);
    apply_config(32'(DROP_LEVEL_RST), 32'(MIN_THRESHOLD_RST), 32'(THRESH_STEP_RST),
                 32'(SUSP_NEEDED_RST), 32'(VAR_LIMIT_RST), 32'(MIN_RISE_RST), 1);
    issue_item(OP_CLEAR, 0, 1'b0, 1'b0, 1'b0);
    run_session(12, 500, 10);
  endtask

  task automatic test_random_phases();
    int stop_at, pick, drive_len, spread;
    for (int ph = 0; ph < 8; ph++) begin
      apply_config(extreme_or_any(0, 65535),
                   extreme_or_any(0, 65535),
                   $urandom_range(0, 1) ? extreme_or_any(0, 65535) : $urandom_range(0, 1000),
                   ($urandom_range(0, 3) == 0) ? extreme_or_any(1, 255) : $urandom_range(1, 4),
                   $urandom_range(0, 1) ? extreme_or_any(0, 1 << 30) : $urandom_range(0, 50000),
                   extreme_or_any(0, 65535) % ($urandom_range(0, 1) ? 65536 : 200),
                   32'($urandom_range(0, 4) != 0));
      calm = (ph >= 6);
      gap_odds = $urandom_range(1, 8);
      stall_odds = $urandom_range(1, 8);
      stop_at = items_issued + 26;
      while (items_issued < stop_at) begin
        if ($urandom_range(0, 3) == 0)
          issue_item(OP_CLEAR, rand_word(), rand_bit(), rand_bit(), rand_bit());
        pick = $urandom_range(0, 9);
        drive_len = (pick < 7) ? $urandom_range(2, 30) :
                    (pick < 9) ? $urandom_range(30, 80) : $urandom_range(100, 160);
        spread = ($urandom_range(0, 5) == 0) ? 0 : (1 << $urandom_range(0, 16)) - 1;
        run_session(drive_len, spread, $urandom_range(1, 12));
      end
    end
  endtask

  initial begin
    win_count = 0;
    win_slot = 0;
    win_sum = 0;
    win_sumsq = 0;
    r_drop = 32'(DROP_LEVEL_RST);
    r_min_thr = 32'(MIN_THRESHOLD_RST);
    r_step = 32'(THRESH_STEP_RST);
    r_needed = 32'(SUSP_NEEDED_RST);
    r_var_limit = 64'(VAR_LIMIT_RST);
    r_min_rise = 32'(MIN_RISE_RST);
    r_adjust_en = 1'b1;
    cur_level = 32'(DROP_LEVEL_RST);
    susp_tally = 0;
    scan_low = 32'(SCAN_MIN_RST);
    scan_on = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_stop_disabled();
    test_window_wrap();
    test_config_extremes();
    test_random_phases();
    wait_idle();
    $display("tb_top: %0d items, %0d results checked over directed, window wrap,",
             items_issued, results_checked);
    $display("tb_top: config extremes and random phases; %0d sends, %0d suspicious, %0d cliffy",
             sends_seen, suspicious_count, cliffy_count);
    if (error_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // result side backpressure
  initial begin
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, stall_odds) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected, threshold %0d", $time, threshold);
        error_count++;
      end else begin
        head_result = pending_results[0];
        pending_results.delete(0);
        check_field("threshold", head_result.threshold, threshold);
        check_field("threshold_sent", 16'(head_result.sent), 16'(threshold_sent));
        check_field("floor_cliffy", 16'(head_result.cliffy), 16'(floor_cliffy));
        check_field("suspicious_seen", 16'(head_result.seen), 16'(suspicious_seen));
        check_field("window_fill", 16'(head_result.fill), 16'(window_fill));
        results_checked++;
        sends_seen += int'(head_result.sent);
        suspicious_count += int'(head_result.seen);
        cliffy_count += int'(head_result.cliffy);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog, no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/act_pkg.sv
rtl/act_mul.sv
rtl/adaptive_cliff_threshold.sv
tb/tb_top.sv
